FILE: hw/rtl/spi_nor_program_erase_sequencer_defines.svh
// ----------------------------------------------------------------------------
// SPI NOR sequencer assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet during rst.
// ----------------------------------------------------------------------------
`ifndef SPI_NOR_PROGRAM_ERASE_SEQUENCER_DEFINES_SVH
`define SPI_NOR_PROGRAM_ERASE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SPINOR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPINOR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/spinor_pkg.sv
// ----------------------------------------------------------------------------
// spinor_pkg
// Types, codes and word tables shared by the SPI NOR sequencer modules.
// ----------------------------------------------------------------------------
package spinor_pkg;

  localparam int PAGE_BYTES    = 256;
  localparam int SECTOR_BYTES  = 4096;
  localparam int PAGE_LOG      = $clog2(PAGE_BYTES);
  localparam int SECTOR_LOG    = $clog2(SECTOR_BYTES);
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [24:0] FLASH_SIZE_RST = 25'h1000000;

  // request ops
  localparam logic [2:0] OP_BEGIN_PROG  = 3'd0;
  localparam logic [2:0] OP_PROG_BYTE   = 3'd1;
  localparam logic [2:0] OP_BEGIN_ERASE = 3'd2;
  localparam logic [2:0] OP_CONT_ERASE  = 3'd3;
  localparam logic [2:0] OP_STATUS      = 3'd4;

  // command word kinds
  localparam logic [2:0] KIND_SEL     = 3'd0;
  localparam logic [2:0] KIND_DESEL   = 3'd1;
  localparam logic [2:0] KIND_SEND    = 3'd2;
  localparam logic [2:0] KIND_READ    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  // flash opcodes
  localparam logic [7:0] FL_WREN  = 8'h06;
  localparam logic [7:0] FL_PP    = 8'h02;
  localparam logic [7:0] FL_SE    = 8'h20;
  localparam logic [7:0] FL_RDSR  = 8'h05;

  // word slots of one job, emitted in ascending order
  localparam int SLOT_N = 15;
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SL_WE_SEL   = 4'd0;
  localparam logic [SLOT_W-1:0] SL_WE_CMD   = 4'd1;
  localparam logic [SLOT_W-1:0] SL_WE_DESEL = 4'd2;
  localparam logic [SLOT_W-1:0] SL_SEL      = 4'd3;
  localparam logic [SLOT_W-1:0] SL_CMD      = 4'd4;
  localparam logic [SLOT_W-1:0] SL_ADDR_HI  = 4'd5;
  localparam logic [SLOT_W-1:0] SL_ADDR_MID = 4'd6;
  localparam logic [SLOT_W-1:0] SL_ADDR_LO  = 4'd7;
  localparam logic [SLOT_W-1:0] SL_DATA     = 4'd8;
  localparam logic [SLOT_W-1:0] SL_DESEL    = 4'd9;
  localparam logic [SLOT_W-1:0] SL_POLL_SEL = 4'd10;
  localparam logic [SLOT_W-1:0] SL_POLL_CMD = 4'd11;
  localparam logic [SLOT_W-1:0] SL_POLL_RD  = 4'd12;
  localparam logic [SLOT_W-1:0] SL_DONE     = 4'd13;
  localparam logic [SLOT_W-1:0] SL_INVALID  = 4'd14;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_PROG  = 4'b0010,
    PH_ERASE = 4'b0100,
    PH_POLL  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [23:0] offset;
    logic [24:0] length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } cmd_t;

  // classified work for the back end
  typedef struct packed {
    logic        hdr;      // write enable + opcode + address
    logic        data;
    logic        desel;
    logic        poll;
    logic        done;
    logic        invalid;
    logic [7:0]  opcode;
    logic [23:0] addr;
    logic [7:0]  data_byte;
  } job_t;

  function automatic logic [SLOT_N-1:0] job_mask(input job_t j);
    logic [SLOT_N-1:0] m;
    m = '0;
    m[SL_ADDR_LO:SL_WE_SEL]   = {8{j.hdr}};
    m[SL_DATA]                = j.data;
    m[SL_DESEL]               = j.desel;
    m[SL_POLL_RD:SL_POLL_SEL] = {3{j.poll}};
    m[SL_DONE]                = j.done;
    m[SL_INVALID]             = j.invalid;
    return m;
  endfunction

  // kind and value of one slot; last is filled in by the caller
  function automatic cmd_t slot_word(input logic [SLOT_W-1:0] s, input job_t j);
    cmd_t w;
    w = '0;
    case (s)
      SL_WE_SEL:   w.kind = KIND_SEL;
      SL_WE_CMD:   begin w.kind = KIND_SEND; w.value = FL_WREN; end
      SL_WE_DESEL: w.kind = KIND_DESEL;
      SL_SEL:      w.kind = KIND_SEL;
      SL_CMD:      begin w.kind = KIND_SEND; w.value = j.opcode; end
      SL_ADDR_HI:  begin w.kind = KIND_SEND; w.value = j.addr[23:16]; end
      SL_ADDR_MID: begin w.kind = KIND_SEND; w.value = j.addr[15:8]; end
      SL_ADDR_LO:  begin w.kind = KIND_SEND; w.value = j.addr[7:0]; end
      SL_DATA:     begin w.kind = KIND_SEND; w.value = j.data_byte; end
      SL_DESEL:    w.kind = KIND_DESEL;
      SL_POLL_SEL: w.kind = KIND_SEL;
      SL_POLL_CMD: begin w.kind = KIND_SEND; w.value = FL_RDSR; end
      SL_POLL_RD:  w.kind = KIND_READ;
      SL_DONE:     w.kind = KIND_DONE;
      default:     w.kind = KIND_INVALID;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/spinor_front.sv
// ----------------------------------------------------------------------------
// spinor_front
// Accepts requests, tracks the program/erase phase and classifies each word.
// ----------------------------------------------------------------------------
`include "spi_nor_program_erase_sequencer_defines.svh"

module spinor_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [24:0]       cfg_data,
  input  logic              req_valid,
  input  spinor_pkg::req_t  req,
  input  logic              q_full,
  output logic              push,
  output spinor_pkg::job_t  job
);

  spinor_pkg::phase_t phase, phase_next;
  logic [24:0] flash_size;
  logic [23:0] base_offset, base_offset_next;
  logic [24:0] total_length, total_length_next;
  logic [24:0] position, position_next;

  logic        range_bad, sect_bad, len_zero;
  logic [24:0] pos_inc;
  logic [25:0] pos_sect;
  logic [24:0] addr_sum;
  logic        page_start, page_end, at_end;

  assign push = req_valid && !q_full;

  always_comb begin
    range_bad  = ({1'b0, req.offset} > flash_size) ||
                 ({2'b00, req.offset} + {1'b0, req.length} > {1'b0, flash_size});
    sect_bad   = |req.length[spinor_pkg::SECTOR_LOG-1:0];
    len_zero   = (req.length == '0);
    pos_inc    = position + 25'd1;
    pos_sect   = {1'b0, position} + 26'(spinor_pkg::SECTOR_BYTES);
    addr_sum   = {1'b0, base_offset} + position;
    page_start = (position[spinor_pkg::PAGE_LOG-1:0] == '0);
    page_end   = (pos_inc[spinor_pkg::PAGE_LOG-1:0] == '0);
    at_end     = (pos_inc >= total_length);
  end

  always_comb begin
    phase_next        = phase;
    base_offset_next  = base_offset;
    total_length_next = total_length;
    position_next     = position;
    job               = '0;
    job.addr          = addr_sum[23:0];
    job.data_byte     = req.data_byte;
    job.opcode        = spinor_pkg::FL_PP;
    case (req.op)
      spinor_pkg::OP_BEGIN_PROG, spinor_pkg::OP_BEGIN_ERASE: begin
        if (phase != spinor_pkg::PH_IDLE) begin
          job.invalid = 1'b1;
        end else if (len_zero) begin
          job.done = 1'b1;
        end else if (range_bad ||
                     (req.op == spinor_pkg::OP_BEGIN_ERASE && sect_bad)) begin
          job.invalid = 1'b1;
        end else begin
          base_offset_next  = req.offset;
          total_length_next = req.length;
          position_next     = '0;
          phase_next        = (req.op == spinor_pkg::OP_BEGIN_PROG) ?
                              spinor_pkg::PH_PROG : spinor_pkg::PH_ERASE;
        end
      end
      spinor_pkg::OP_PROG_BYTE: begin
        if (phase != spinor_pkg::PH_PROG) begin
          job.invalid = 1'b1;
        end else begin
          job.hdr       = page_start;
          job.data      = 1'b1;
          job.desel     = at_end || page_end;
          job.poll      = at_end;
          position_next = pos_inc;
          if (at_end) phase_next = spinor_pkg::PH_POLL;
        end
      end
      spinor_pkg::OP_CONT_ERASE: begin
        if (phase != spinor_pkg::PH_ERASE) begin
          job.invalid = 1'b1;
        end else begin
          job.hdr       = 1'b1;
          job.opcode    = spinor_pkg::FL_SE;
          job.desel     = 1'b1;
          position_next = pos_sect[24:0];
          if (pos_sect >= {1'b0, total_length}) begin
            job.poll   = 1'b1;
            phase_next = spinor_pkg::PH_POLL;
          end
        end
      end
      spinor_pkg::OP_STATUS: begin
        if (phase != spinor_pkg::PH_POLL) begin
          job.invalid = 1'b1;
        end else begin
          job.desel = 1'b1;
          if (req.data_byte[0]) begin
            job.poll = 1'b1;
          end else begin
            job.done   = 1'b1;
            phase_next = spinor_pkg::PH_IDLE;
          end
        end
      end
      default: job.invalid = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= spinor_pkg::PH_IDLE;
      flash_size   <= spinor_pkg::FLASH_SIZE_RST;
      base_offset  <= '0;
      total_length <= '0;
      position     <= '0;
    end else begin
      if (cfg_valid) flash_size <= cfg_data;
      if (push) begin
        phase        <= phase_next;
        base_offset  <= base_offset_next;
        total_length <= total_length_next;
        position     <= position_next;
      end
    end
  end

  `SPINOR_ASSERT(a_prog_pos, phase == spinor_pkg::PH_PROG, position < total_length, "program position ran past length")
  `SPINOR_ASSERT(a_erase_pos, phase == spinor_pkg::PH_ERASE, position < total_length, "erase position ran past length")

endmodule

FILE: hw/rtl/spinor_queue.sv
// ----------------------------------------------------------------------------
// spinor_queue
// Small job FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`include "spi_nor_program_erase_sequencer_defines.svh"

module spinor_queue #(
  parameter int QUEUE_DEPTH = spinor_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  spinor_pkg::job_t wr_job,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output spinor_pkg::job_t rd_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  spinor_pkg::job_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `SPINOR_ASSERT(a_no_overflow, push, !full, "job queue overflow")
  `SPINOR_ASSERT(a_no_underflow, pop, nonempty, "job queue underflow")

endmodule

FILE: hw/rtl/spinor_back.sv
// ----------------------------------------------------------------------------
// spinor_back
// Expands queued jobs into SPI command words, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "spi_nor_program_erase_sequencer_defines.svh"

module spinor_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  spinor_pkg::job_t q_job,
  output logic             pop,
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output spinor_pkg::cmd_t cmd
);

  logic [spinor_pkg::SLOT_N-1:0] pend, pick, rest;
  logic [spinor_pkg::SLOT_W-1:0] slot;
  spinor_pkg::job_t              cur;
  spinor_pkg::cmd_t              word;
  logic                          advance;

  assign advance = !cmd_valid || !cmd_stall;
  assign pop     = (pend == '0) && q_nonempty;

  always_comb begin
    pick = pend & (~pend + 1'b1);
    rest = pend & ~pick;
    slot = '0;
    for (int i = 0; i < spinor_pkg::SLOT_N; i++) begin
      if (pick[i]) slot = slot | spinor_pkg::SLOT_W'(i);
    end
    word      = spinor_pkg::slot_word(slot, cur);
    word.last = (rest == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (advance) begin
        cmd_valid <= (pend != '0);
        if (pend != '0) pend <= rest;
      end
      if (pop) pend <= spinor_pkg::job_mask(q_job);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_job;
    if (advance && pend != '0) cmd <= word;
  end

  `SPINOR_ASSERT_NEXT(a_one_slot, (pend != '0) && advance, $countones(pend) + 1 == $countones($past(pend)), "back end skipped or repeated a word")

endmodule

FILE: hw/rtl/spi_nor_program_erase_sequencer.sv
// ----------------------------------------------------------------------------
// spi_nor_program_erase_sequencer
// SPI NOR page program / sector erase command sequencer, top level.
// ----------------------------------------------------------------------------
// Path: a request goes through the job queue into the back end, whose words
//   are registered into cmd. Throughput: one request per cycle into the queue
//   unless it is full; the back end takes a new job only once the last one's
//   words (0 to 13) are out, at one word per cycle while cmd_stall is low.
// Reset (rst, synchronous): phase idle, queue and output empty, flash_size
//   back to 16 MiB; no clearing pass.

module spi_nor_program_erase_sequencer #(
  parameter int QUEUE_DEPTH = spinor_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // flash size register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [24:0]      cfg_data,
  // requests
  input  logic             req_valid,
  output logic             req_stall,
  input  spinor_pkg::req_t req,
  // command words to the SPI master
  output logic             cmd_valid,
  input  logic             cmd_stall,
  output spinor_pkg::cmd_t cmd
);

  // Front end owns all sequencing state, so it never waits on the back end
  // except when the job queue is full.
  logic             push, q_full, q_nonempty, pop;
  spinor_pkg::job_t wr_job, rd_job;

  // user must keep register writes to idle; not enforced, always taken
  assign cfg_ready = 1'b1;
  assign req_stall = q_full;

  spinor_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (wr_job)
  );

  // decouples classification from word expansion
  spinor_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .rd_job   (rd_job)
  );

  // one command word per cycle into the registered output, unless stalled
  spinor_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_job      (rd_job),
    .pop        (pop),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd)
  );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR program / erase sequencer testbench
// Drives request words and flash size writes into the sequencer, predicts
// every command word from a behavioural copy of the sequencer kept here, and
// checks each command word the block hands over, in order, field by field.
// ----------------------------------------------------------------------------

module tb;
  import spinor_pkg::*;

  localparam int unsigned CLK_HALF    = 6;
  localparam int unsigned QUIET_LIMIT = 2000;   // cycles with no word moving
  localparam int unsigned TAIL_CYCLES = 16;     // settle time after the last word
  localparam int unsigned LONG_HOLD   = 300;    // receiver hold-off, in cycles
  localparam logic [2:0]  OP_RSVD_LO  = OP_STATUS + 3'd1;  // first unused op

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [24:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        cmd_valid;
  logic        cmd_stall = 1'b0;
  cmd_t        cmd;

  // behavioural copy of the sequencer state
  phase_t      m_phase;
  logic [24:0] m_flash_size;
  logic [23:0] m_base;
  logic [24:0] m_total;
  logic [24:0] m_pos;

  cmd_t        cmd_due[$];     // command words still owed by the block
  cmd_t        step_words[$];  // words caused by the request being expanded

  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned send_gap_pct;   // chance of an idle burst after a request word
  int unsigned sink_pct;       // chance of a stall burst on the command side
  int unsigned hold_len;
  int unsigned hold_trig;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned stall_left;

  spi_nor_program_erase_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void emit(input logic [2:0] k, input logic [7:0] v);
    cmd_t w;
    w.kind  = k;
    w.value = (k == KIND_SEND) ? v : 8'h00;
    w.last  = 1'b0;
    step_words.push_back(w);
  endfunction

  // 24-bit address, most significant byte first
  function automatic void emit_addr(input logic [23:0] a);
    emit(KIND_SEND, a[23:16]);
    emit(KIND_SEND, a[15:8]);
    emit(KIND_SEND, a[7:0]);
  endfunction

  function automatic void emit_wren();
    emit(KIND_SEL, 8'h00);
    emit(KIND_SEND, FL_WREN);
    emit(KIND_DESEL, 8'h00);
  endfunction

  function automatic void emit_poll();
    emit(KIND_SEL, 8'h00);
    emit(KIND_SEND, FL_RDSR);
    emit(KIND_READ, 8'h00);
    m_phase = PH_POLL;
  endfunction

  // Zero length wins over the range check; erase also needs whole sectors.
  function automatic bit open_request(input req_t r, input bit erase);
    logic [25:0] span;
    span = {2'b00, r.offset} + {1'b0, r.length};
    if (r.length == 25'd0) begin
      emit(KIND_DONE, 8'h00);
      return 1'b0;
    end
    if ({1'b0, r.offset} > m_flash_size || span > {1'b0, m_flash_size}) begin
      emit(KIND_INVALID, 8'h00);
      return 1'b0;
    end
    if (erase && (r.length % SECTOR_BYTES) != 0) begin
      emit(KIND_INVALID, 8'h00);
      return 1'b0;
    end
    m_base  = r.offset;
    m_total = r.length;
    m_pos   = 25'd0;
    return 1'b1;
  endfunction

  // Expands one accepted request word into the command words it owes.
  function automatic void expand_request(input req_t r);
    logic [25:0] nxt_pos;
    cmd_t        w;
    step_words.delete();
    case (r.op)
      OP_BEGIN_PROG: begin
        if (m_phase != PH_IDLE) emit(KIND_INVALID, 8'h00);
        else if (open_request(r, 1'b0)) m_phase = PH_PROG;
      end
      OP_PROG_BYTE: begin
        if (m_phase != PH_PROG) begin
          emit(KIND_INVALID, 8'h00);
        end else begin
          // chunks are counted from the request start, not the flash address
          if ((m_pos % PAGE_BYTES) == 0) begin
            emit_wren();
            emit(KIND_SEL, 8'h00);
            emit(KIND_SEND, FL_PP);
            emit_addr(m_base + m_pos[23:0]);
          end
          emit(KIND_SEND, r.data_byte);
          m_pos = m_pos + 25'd1;
          if (m_pos >= m_total || (m_pos % PAGE_BYTES) == 0) emit(KIND_DESEL, 8'h00);
          if (m_pos >= m_total) emit_poll();
        end
      end
      OP_BEGIN_ERASE: begin
        if (m_phase != PH_IDLE) emit(KIND_INVALID, 8'h00);
        else if (open_request(r, 1'b1)) m_phase = PH_ERASE;
      end
      OP_CONT_ERASE: begin
        if (m_phase != PH_ERASE) begin
          emit(KIND_INVALID, 8'h00);
        end else begin
          emit_wren();
          emit(KIND_SEL, 8'h00);
          emit(KIND_SEND, FL_SE);
          emit_addr(m_base + m_pos[23:0]);
          emit(KIND_DESEL, 8'h00);
          nxt_pos = {1'b0, m_pos} + 26'(SECTOR_BYTES);
          m_pos   = nxt_pos[24:0];
          if (nxt_pos >= {1'b0, m_total}) emit_poll();
        end
      end
      OP_STATUS: begin
        if (m_phase != PH_POLL) begin
          emit(KIND_INVALID, 8'h00);
        end else begin
          emit(KIND_DESEL, 8'h00);
          // busy bit still set: poll again
          if (r.data_byte[0]) begin
            emit_poll();
          end else begin
            emit(KIND_DONE, 8'h00);
            m_phase = PH_IDLE;
          end
        end
      end
      default: emit(KIND_INVALID, 8'h00);
    endcase
    // an accepted begin request owes nothing
    if (step_words.size() != 0) begin
      w = step_words.pop_back();
      w.last = 1'b1;
      step_words.push_back(w);
    end
    foreach (step_words[i]) cmd_due.push_back(step_words[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  function automatic void report_mismatch(input string fld, input logic [7:0] e,
                                          input logic [7:0] a);
    errors++;
    $display("%0t: command word %s mismatch: expected %02h, got %02h", $time, fld, e, a);
  endfunction

  always @(posedge clk) begin : cmd_check
    cmd_t exp_w;
    if (!rst && cmd_valid && !cmd_stall) begin
      if (cmd_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected command word: expected none, got kind %0d value %02h last %0b",
                 $time, cmd.kind, cmd.value, cmd.last);
      end else begin
        exp_w = cmd_due.pop_front();
        if (cmd.kind !== exp_w.kind) report_mismatch("kind", 8'(exp_w.kind), 8'(cmd.kind));
        if (cmd.value !== exp_w.value) report_mismatch("value", exp_w.value, cmd.value);
        if (cmd.last !== exp_w.last) report_mismatch("last", 8'(exp_w.last), 8'(cmd.last));
      end
    end
  end

  // Runs out only if the block stops moving words on every port.
  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (cmd_valid && !cmd_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("** spi_nor_program_erase_sequencer: FAILED **");
      $finish;
    end
  end

  // Command side: random stall bursts, plus a long hold-off on request,
  // counted here.
  always @(negedge clk) begin : cmd_sink
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = hold_len;
    end
    if (hold_left != 0) begin
      hold_left--;
      cmd_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      cmd_stall <= 1'b1;
    end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
      stall_left = $urandom_range(0, 13);
      cmd_stall <= 1'b1;
    end else begin
      cmd_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic req_t mk_req(input logic [2:0] op, input logic [23:0] off,
                                  input logic [24:0] len, input logic [7:0] db);
    req_t r;
    r.op        = op;
    r.offset    = off;
    r.length    = len;
    r.data_byte = db;
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with the word taken.
  task automatic send_req(input req_t r);
    int unsigned gap;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    expand_request(r);
    @(negedge clk);
    gap = 0;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_flash_size(input logic [24:0] sz);
    cfg_data  <= sz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    m_flash_size = sz;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender pauses until every owed word has arrived, then lets the block
  // settle, since an accepted begin request leaves nothing to wait for.
  task automatic wait_results_done();
    req_valid <= 1'b0;
    while (cmd_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // Follows the sequence the block expects, with some noise mixed in.
  function automatic req_t pick_request();
    req_t        r;
    int unsigned n;
    r.op        = OP_PROG_BYTE;
    r.offset    = 24'($urandom);
    r.length    = 25'($urandom);
    r.data_byte = 8'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      r.op = 3'($urandom);
      // a stray begin must never open a huge session
      if (r.op == OP_BEGIN_PROG || r.op == OP_BEGIN_ERASE) begin
        r.length[24] = 1'b1;
        r.offset[23] = 1'b1;
      end
      return r;
    end
    case (m_phase)
      PH_PROG:  r.op = OP_PROG_BYTE;
      PH_ERASE: r.op = OP_CONT_ERASE;
      PH_POLL: begin
        r.op = OP_STATUS;
        r.data_byte[0] = ($urandom_range(0, 99) < 35);
      end
      default: begin
        if ($urandom_range(0, 99) < 55) begin
          r.op     = OP_BEGIN_PROG;
          r.length = 25'($urandom_range(1, 12));
        end else begin
          r.op     = OP_BEGIN_ERASE;
          r.length = 25'($urandom_range(1, 3) * SECTOR_BYTES);
        end
        n = $urandom_range(0, 99);
        if (r.length <= m_flash_size)
          r.offset = 24'($urandom_range(0, 32'(m_flash_size - r.length)));
        if (n < 5) begin
          r.length = 25'd0;
        end else if (n < 12 && r.op == OP_BEGIN_ERASE) begin
          r.length = r.length + 25'($urandom_range(1, SECTOR_BYTES - 1));
        end else if (n >= 12 && n < 20) begin
          // ends past the top of the flash
          r.offset = m_flash_size[23:0] - 24'($urandom_range(0, 32'(r.length) - 1));
        end
      end
    endcase
    return r;
  endfunction

  // Field extremes, every op, zero length, range and alignment failures,
  // wrong-phase requests, busy polling and the twelve-word sector erase.
  task automatic test_directed_cases();
    send_gap_pct = 20;
    sink_pct     = 20;
    send_req(mk_req(OP_BEGIN_PROG, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_BEGIN_ERASE, 24'hFFFFFF, 25'd0, 8'h00));
    send_req(mk_req(OP_BEGIN_PROG, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF));
    send_req(mk_req(OP_BEGIN_PROG, 24'h000001, 25'h1000000, 8'h00));
    send_req(mk_req(OP_BEGIN_ERASE, 24'h000000, 25'(SECTOR_BYTES + 1), 8'h00));
    send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'h5A));
    send_req(mk_req(OP_CONT_ERASE, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h01));
    for (int k = 0; k < 3; k++)
      send_req(mk_req(OP_RSVD_LO + 3'(k), 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_BEGIN_PROG, 24'hFFFFFE, 25'd2, 8'h00));
    send_req(mk_req(OP_BEGIN_ERASE, 24'h000000, 25'(SECTOR_BYTES), 8'h00));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'hFF));
    send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'h33));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h01));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'hFE));
    send_req(mk_req(OP_BEGIN_ERASE, 24'hFFF000, 25'(SECTOR_BYTES), 8'h00));
    send_req(mk_req(OP_BEGIN_PROG, 24'h000000, 25'd1, 8'h00));
    send_req(mk_req(OP_CONT_ERASE, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'hFF));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h00));
    wait_results_done();
  endtask

  // Range checks against the smallest and a random flash size.
  task automatic test_flash_size_limits();
    logic [24:0] sz;
    send_gap_pct = 0;
    sink_pct     = 0;
    write_flash_size(25'(SECTOR_BYTES));
    send_req(mk_req(OP_BEGIN_PROG, 24'(SECTOR_BYTES - 1), 25'd1, 8'h00));
    send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'hA5));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_BEGIN_PROG, 24'(SECTOR_BYTES), 25'd1, 8'h00));
    send_req(mk_req(OP_BEGIN_PROG, 24'(SECTOR_BYTES + 1), 25'd0, 8'h00));
    send_req(mk_req(OP_BEGIN_ERASE, 24'(SECTOR_BYTES + 1), 25'(SECTOR_BYTES), 8'h00));
    send_req(mk_req(OP_BEGIN_ERASE, 24'h000000, 25'(2 * SECTOR_BYTES), 8'h00));
    send_req(mk_req(OP_BEGIN_ERASE, 24'h000000, 25'(SECTOR_BYTES), 8'h00));
    send_req(mk_req(OP_CONT_ERASE, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h00));
    wait_results_done();
    sz = 25'($urandom_range(SECTOR_BYTES, 32'(FLASH_SIZE_RST) - 1));
    write_flash_size(sz);
    send_req(mk_req(OP_BEGIN_PROG, 24'(sz - 25'd1), 25'd1, 8'h00));
    send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'h3C));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h00));
    send_req(mk_req(OP_BEGIN_PROG, 24'(sz), 25'd1, 8'h00));
    wait_results_done();
    write_flash_size(FLASH_SIZE_RST);
  endtask

  // A program crossing a chunk boundary while the command side holds off for
  // a long stretch, so the block fills and stalls its request input.
  task automatic test_backpressure();
    logic [23:0] off;
    send_gap_pct = 0;
    sink_pct     = 0;
    off = 24'($urandom_range(0, 32'(FLASH_SIZE_RST) - PAGE_BYTES - 2));
    send_req(mk_req(OP_BEGIN_PROG, off, 25'(PAGE_BYTES + 2), 8'h00));
    hold_len = LONG_HOLD;
    hold_trig++;
    repeat (PAGE_BYTES + 2) send_req(mk_req(OP_PROG_BYTE, 24'h000000, 25'd0, 8'($urandom)));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h01));
    send_req(mk_req(OP_STATUS, 24'h000000, 25'd0, 8'h00));
    wait_results_done();
  endtask

  // Random sessions over several flash sizes; the last stretch runs flat out.
  task automatic test_random_traffic();
    int unsigned sent;
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: write_flash_size(25'($urandom_range(SECTOR_BYTES, 16 * SECTOR_BYTES)));
        2: write_flash_size(25'($urandom_range(SECTOR_BYTES, 32'(FLASH_SIZE_RST))));
        default: write_flash_size(FLASH_SIZE_RST);
      endcase
      send_gap_pct = (seg == 3) ? 0 : 10 + 15 * seg;
      sink_pct     = (seg == 3) ? 0 : 40 - 15 * seg;
      sent = 0;
      while (sent < 40 || m_phase != PH_IDLE) begin
        send_req(pick_request());
        sent++;
      end
      wait_results_done();
    end
  endtask

  initial begin : run
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    quiet_cycles = 0;
    send_gap_pct = 0;
    sink_pct     = 0;
    hold_len     = 0;
    hold_trig    = 0;
    hold_seen    = 0;
    hold_left    = 0;
    stall_left   = 0;
    m_phase      = PH_IDLE;
    m_flash_size = FLASH_SIZE_RST;
    m_base       = '0;
    m_total      = '0;
    m_pos        = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_flash_size_limits();
    test_backpressure();
    test_random_traffic();
    if (cmd_due.size() != 0) begin
      errors++;
      $display("%0t: %0d command words never arrived", $time, cmd_due.size());
    end
    if (errors == 0) begin
      $display("** spi_nor_program_erase_sequencer: PASSED **");
    end else begin
      $display("** spi_nor_program_erase_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/spinor_pkg.sv
hw/rtl/spinor_front.sv
hw/rtl/spinor_queue.sv
hw/rtl/spinor_back.sv
hw/rtl/spi_nor_program_erase_sequencer.sv
dv/tb.sv
